// ===== sv/jlpg_pkg.sv =====
// Package for the jerk-limited profile generator: field widths, register
// indexes, reset values, the divide-by-six constants and the result type.
// No dependencies.
`timescale 1ns / 1ps

package jlpg_pkg;

  localparam int POS_W      = 64;
  localparam int VEL_W      = 48;
  localparam int ACC_W      = 40;
  localparam int TICK_W     = 16;
  localparam int JERK_W     = 24;
  localparam int SEG_W      = 3;
  localparam int NUM_SEG    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 160;

  localparam logic [SEG_W-1:0] SEG_DONE = 3'd7;

  localparam logic [TICK_W-1:0] RST_TICKS = 16'd1000;
  localparam logic [JERK_W-1:0] RST_JERK  = 24'd2161728;

  // floor(x / 6) for x in (-2^24, 2^24 + 3): bias by 6 * 2^22, then
  // multiply by ceil(2^29 / 6) and shift; exact for biased values below 2^27
  localparam int DIV6_IN_W  = 26;
  localparam int DIV6_REC_W = 27;
  localparam int DIV6_SHIFT = 29;
  localparam logic [DIV6_IN_W-1:0]  DIV6_BIAS  = 26'd25165824;
  localparam logic [DIV6_REC_W-1:0] DIV6_RECIP = 27'd89478486;
  localparam logic [JERK_W:0]       DIV6_BIAS_Q = 25'd4194304;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_UP    = 3'd0,
    REG_ACCEL_HOLD = 3'd1,
    REG_CRUISE     = 3'd2,
    REG_RAMP_DOWN  = 3'd3,
    REG_DECEL_HOLD = 3'd4,
    REG_ACCEL_JERK = 3'd5,
    REG_DECEL_JERK = 3'd6
  } cfg_reg_t;

  // position sits in the lowest bits
  typedef struct packed {
    logic                    done_res;
    logic [SEG_W-1:0]        segment;
    logic signed [ACC_W-1:0] acceleration;
    logic signed [VEL_W-1:0] velocity;
    logic signed [POS_W-1:0] position;
  } result_t;

  // first segment after s with a nonzero length, else SEG_DONE
  function automatic logic [SEG_W-1:0] next_seg(input logic [NUM_SEG-1:0] nz,
                                                input logic [SEG_W-1:0] s);
    logic [SEG_W-1:0] r;
    r = SEG_DONE;
    for (int k = NUM_SEG - 1; k >= 0; k--) begin
      if ((SEG_W'(k) > s) && nz[k]) begin
        r = SEG_W'(k);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/jerk_limited_profile_generator_top.sv =====
// Top level of the jerk-limited seven-segment S-curve profile generator.
// Depends on jlpg_pkg.
`timescale 1ns / 1ps

// Usage:
//   s_tvalid/s_tready/s_tdata carry one command per transfer: s_tdata[0] is
//   restart (1 clears the profile to zero at segment 0, 0 advances one tick).
//   m_tvalid/m_tready/m_tdata return one result per command: position,
//   velocity, acceleration after the command, the segment (7 = finished)
//   and done_res.
//   cfg_wr_en/cfg_index/cfg_wdata write the segment lengths and jerks; write
//   only while no command is in flight. Index 7 is ignored.
//   The result is registered in the output register, or in the skid
//   register while the output is stalled. Throughput: one command
//   per cycle while s_tready is high; the cubic update, segment skip and
//   saturation are combinational; the divide by six is a 26x27 multiply.
//   Stall: a skid register holds one extra result, so a command is still
//   taken while a result waits; s_tready drops only when both are full.
//   Reset: registers return to their defaults, the profile is zero at
//   segment 0 and no result is pending.
module jerk_limited_profile_generator_top
  import jlpg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] restart, rest zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // position, velocity,
                                            // acceleration, segment, done_res
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DP_W  = VEL_W + 2;
  localparam int VS_W  = VEL_W + 2;
  localparam int PROD_W = DIV6_IN_W + DIV6_REC_W;

  logic [TICK_W-1:0] ramp_up_ticks, accel_hold_ticks, cruise_ticks;
  logic [TICK_W-1:0] ramp_down_ticks, decel_hold_ticks;
  logic [JERK_W-1:0] accel_jerk, decel_jerk;

  logic [SEG_W-1:0]        seg_index, seg_index_next;
  logic [TICK_W-1:0]       seg_tick, seg_tick_next;
  logic signed [ACC_W-1:0] accel_acc, accel_acc_next;
  logic signed [VEL_W-1:0] vel_acc, vel_acc_next;
  logic signed [POS_W-1:0] pos_acc, pos_acc_next;

  result_t out_data, skid_data, result;
  logic    out_valid, skid_valid;
  logic    accept, out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_up_ticks    <= RST_TICKS;
      accel_hold_ticks <= RST_TICKS;
      cruise_ticks     <= RST_TICKS;
      ramp_down_ticks  <= RST_TICKS;
      decel_hold_ticks <= RST_TICKS;
      accel_jerk       <= RST_JERK;
      decel_jerk       <= RST_JERK;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RAMP_UP:    ramp_up_ticks    <= cfg_wdata[TICK_W-1:0];
        REG_ACCEL_HOLD: accel_hold_ticks <= cfg_wdata[TICK_W-1:0];
        REG_CRUISE:     cruise_ticks     <= cfg_wdata[TICK_W-1:0];
        REG_RAMP_DOWN:  ramp_down_ticks  <= cfg_wdata[TICK_W-1:0];
        REG_DECEL_HOLD: decel_hold_ticks <= cfg_wdata[TICK_W-1:0];
        REG_ACCEL_JERK: accel_jerk       <= cfg_wdata[JERK_W-1:0];
        REG_DECEL_JERK: decel_jerk       <= cfg_wdata[JERK_W-1:0];
        default: ;
      endcase
    end
  end

  // segment lengths, entry 7 is the finished state
  logic [TICK_W-1:0]  seg_len [NUM_SEG+1];
  logic [NUM_SEG-1:0] seg_nz;

  always_comb begin
    seg_len[0] = ramp_up_ticks;
    seg_len[1] = accel_hold_ticks;
    seg_len[2] = ramp_up_ticks;
    seg_len[3] = cruise_ticks;
    seg_len[4] = ramp_down_ticks;
    seg_len[5] = decel_hold_ticks;
    seg_len[6] = ramp_down_ticks;
    seg_len[7] = '0;
    for (int k = 0; k < NUM_SEG; k++) begin
      seg_nz[k] = (seg_len[k] != '0);
    end
  end

  logic [SEG_W-1:0]         pre_idx;
  logic [TICK_W-1:0]        pre_tick, tick_inc;
  logic signed [JERK_W:0]   jerk;
  logic signed [DIV6_IN_W-1:0] div_in;
  logic [DIV6_IN_W-1:0]     div_biased;
  logic [PROD_W-1:0]        div_prod;
  logic signed [JERK_W:0]   frac_q;
  logic signed [DP_W-1:0]   dp;
  logic signed [POS_W:0]    pos_sum;
  logic signed [VS_W-1:0]   vel_sum;
  logic signed [ACC_W:0]    acc_sum;

  always_comb begin
    // skip segments already finished (zero length or length lowered)
    if (seg_tick >= seg_len[seg_index]) begin
      pre_idx  = next_seg(seg_nz, seg_index);
      pre_tick = '0;
    end else begin
      pre_idx  = seg_index;
      pre_tick = seg_tick;
    end

    unique case (pre_idx)
      3'd0:    jerk =  $signed({1'b0, accel_jerk});
      3'd2:    jerk = -$signed({1'b0, accel_jerk});
      3'd4:    jerk = -$signed({1'b0, decel_jerk});
      3'd6:    jerk =  $signed({1'b0, decel_jerk});
      default: jerk = '0;
    endcase

    // floor((3a + j) / 6) = floor(a / 2) + floor((3 * (a mod 2) + j) / 6)
    div_in     = DIV6_IN_W'(jerk) + (accel_acc[0] ? DIV6_IN_W'(3) : '0);
    div_biased = DIV6_IN_W'(div_in) + DIV6_BIAS;
    div_prod   = PROD_W'(div_biased) * PROD_W'(DIV6_RECIP);
    frac_q     = $signed({1'b0, div_prod[DIV6_SHIFT +: JERK_W]}) - $signed(DIV6_BIAS_Q);

    dp      = DP_W'(vel_acc) + DP_W'(accel_acc >>> 1) + DP_W'(frac_q);
    pos_sum = (POS_W+1)'(pos_acc) + (POS_W+1)'(dp);
    vel_sum = VS_W'(vel_acc) + VS_W'(accel_acc) + VS_W'(jerk >>> 1);
    acc_sum = (ACC_W+1)'(accel_acc) + (ACC_W+1)'(jerk);
    tick_inc = pre_tick + TICK_W'(1);

    if (s_tdata[0]) begin
      seg_index_next = '0;
      seg_tick_next  = '0;
      accel_acc_next = '0;
      vel_acc_next   = '0;
      pos_acc_next   = '0;
    end else if (pre_idx == SEG_DONE) begin
      seg_index_next = pre_idx;
      seg_tick_next  = pre_tick;
      accel_acc_next = accel_acc;
      vel_acc_next   = vel_acc;
      pos_acc_next   = pos_acc;
    end else begin
      if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
        pos_acc_next = pos_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                      : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
        pos_acc_next = pos_sum[POS_W-1:0];
      end
      if (vel_sum[VS_W-1:VEL_W-1] != {(VS_W-VEL_W+1){vel_sum[VS_W-1]}}) begin
        vel_acc_next = vel_sum[VS_W-1] ? {1'b1, {(VEL_W-1){1'b0}}}
                                       : {1'b0, {(VEL_W-1){1'b1}}};
      end else begin
        vel_acc_next = vel_sum[VEL_W-1:0];
      end
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
        accel_acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        accel_acc_next = acc_sum[ACC_W-1:0];
      end
      if (tick_inc >= seg_len[pre_idx]) begin
        seg_index_next = next_seg(seg_nz, pre_idx);
        seg_tick_next  = '0;
      end else begin
        seg_index_next = pre_idx;
        seg_tick_next  = tick_inc;
      end
    end
  end

  assign result.position     = pos_acc_next;
  assign result.velocity     = vel_acc_next;
  assign result.acceleration = accel_acc_next;
  assign result.segment      = seg_index_next;
  assign result.done_res     = (seg_index_next == SEG_DONE);

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  // profile state
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_index <= '0;
      seg_tick  <= '0;
      accel_acc <= '0;
      vel_acc   <= '0;
      pos_acc   <= '0;
    end else if (accept) begin
      seg_index <= seg_index_next;
      seg_tick  <= seg_tick_next;
      accel_acc <= accel_acc_next;
      vel_acc   <= vel_acc_next;
      pos_acc   <= pos_acc_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_free) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end else if (out_free && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_data);

endmodule
